[hdl/rcds_pkg.sv]
// Shared constants, types and tables for the raster cost-distance sum block.
`timescale 1ns / 1ps
`default_nettype none
package rcds_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int FRAC_BITS = 8;
    localparam int NCELLS    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = $clog2(NCELLS);
    localparam int CNT_W     = $clog2(NCELLS + 1);
    localparam int POS_W     = 6;                        // start_row / start_col width
    localparam int SIDE_W    = 7;
    localparam int COST_W    = 16;
    localparam int CELL_W    = COST_W + 1;               // outside flag above cost
    localparam int DIST_W    = 34;
    localparam int NODE_W    = DIST_W + 1;               // reached flag above distance
    localparam int ORTH_W    = COST_W + FRAC_BITS;
    localparam int SQRT2_Q16 = 92682;
    localparam int DIAG_VAL  = (((SQRT2_Q16 * 2) >> (16 - FRAC_BITS)) + 1) >> 1;
    localparam int DIAG_W    = $clog2(DIAG_VAL + 1);
    localparam int DWGT_W    = COST_W + DIAG_W;
    localparam int MUL_W     = 21;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int G_W       = 2 * POS_W + 1;            // dr^2 + dc^2
    localparam int SUM_W     = 32;
    localparam int INT_W     = DIST_W - FRAC_BITS;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_SIDE   = 2'd0,
        CFG_CSIZE  = 2'd1,
        CFG_RADIUS = 2'd2,
        CFG_MAXSUM = 2'd3
    } t_cfg_idx;

    // neighbor offsets in direction order
    localparam logic signed [1:0] DIR_ROW [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                   2'sd0,  2'sd1,  2'sd1, 2'sd1};
    localparam logic signed [1:0] DIR_COL [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                   2'sd1, -2'sd1, 2'sd0, 2'sd1};

endpackage
`default_nettype wire

[hdl/raster_cost_distance_sum.sv]
// Top level: cell load, relaxation search, radius scan and result register.
//
//  channel | direction | handshake                 | word
//  in      | to block  | i_in_valid / o_in_stall   | cost, outside, start_row/col, last
//  out     | from block| o_out_valid / i_out_stall | cost_sum, capped
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | index, data
//
// Non-last words are stored as taken, back to back while idle with no result pending.
// A last word runs: distance RAM clear, seed, sweeps relaxing each passable cell from
// its eight neighbors (outside cells skip them) in alternating direction until a sweep
// changes nothing, then the PREP1/PREP2 multiplies and a radius scan of every cell, all
// sharing one distance RAM read port and the multiplier. Reset is synchronous, active
// low. A finished result waits in the output register while the next window loads.
`timescale 1ns / 1ps
`default_nettype none
module raster_cost_distance_sum (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [rcds_pkg::COST_W-1:0] i_cost,
    input  wire logic                       i_outside,
    input  wire logic [rcds_pkg::POS_W-1:0] i_start_row,
    input  wire logic [rcds_pkg::POS_W-1:0] i_start_col,
    input  wire logic                       i_last,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [rcds_pkg::SUM_W-1:0]      o_cost_sum,
    output logic                            o_capped,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [30:0]                i_cfg_data
);
    import rcds_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_CLR     = 15'b000000000000010,
        S_SEED_RD = 15'b000000000000100,
        S_SEED    = 15'b000000000001000,
        S_CELL    = 15'b000000000010000,
        S_WGT     = 15'b000000000100000,
        S_NB_RD   = 15'b000000001000000,
        S_NB_CMP  = 15'b000000010000000,
        S_WR      = 15'b000000100000000,
        S_PREP1   = 15'b000001000000000,
        S_PREP2   = 15'b000010000000000,
        S_SC_RD   = 15'b000100000000000,
        S_SC_G    = 15'b001000000000000,
        S_SC_MUL  = 15'b010000000000000,
        S_SC_ACC  = 15'b100000000000000
    } t_state;

    // configuration
    logic [SIDE_W-1:0] r_side;
    logic [9:0]        r_csize;
    logic [19:0]       r_radius;
    logic [30:0]       r_max_sum;

    t_state            r_state;
    logic [CNT_W-1:0]  r_ld_cnt;
    logic [POS_W-1:0]  r_sr, r_sc;
    logic [ADDR_W-1:0] r_st_addr;
    logic              r_st_in;
    logic [ADDR_W-1:0] r_addr;
    logic [POS_W-1:0]  r_row, r_col;
    logic [2:0]        r_dir;
    logic              r_fwd, r_changed, r_imp, r_nb_ok;
    logic [COST_W-1:0] r_cost;
    logic [NODE_W-1:0] r_best;
    logic [19:0]       r_cs2;
    logic [PROD_W-1:0] r_lim;
    logic              r_hit;
    logic [INT_W-1:0]  r_val;
    logic [G_W-1:0]    r_g;
    logic [SUM_W-1:0]  r_sum;
    logic              r_capped;
    logic              r_done;
    logic              r_ovalid;
    logic [SUM_W-1:0]  r_osum;
    logic              r_ocap;

    logic [SIDE_W-1:0] w_n;
    logic [CNT_W-1:0]  w_nn;
    logic [POS_W-1:0]  w_nm1;
    logic              in_acc, out_free;

    always_comb begin
        if (r_side == '0) begin
            w_n = SIDE_W'(1);
        end else if (r_side > SIDE_W'(MAX_SIDE)) begin
            w_n = SIDE_W'(MAX_SIDE);
        end else begin
            w_n = r_side;
        end
    end
    assign w_nn  = CNT_W'(w_n) * CNT_W'(w_n);
    assign w_nm1 = POS_W'(w_n - SIDE_W'(1));

    assign o_in_stall  = (r_state != S_IDLE) || r_done;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ovalid || !i_out_stall;

    // memories
    logic              cell_we;
    logic [ADDR_W-1:0] cell_raddr;
    logic [CELL_W-1:0] cell_q;
    logic              dist_we;
    logic [ADDR_W-1:0] dist_waddr, dist_raddr;
    logic [NODE_W-1:0] dist_wdata, dist_q;

    rcds_ram #(.W(CELL_W), .D(NCELLS), .AW(ADDR_W)) u_cells (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (r_ld_cnt[ADDR_W-1:0]),
        .i_wdata ({i_outside, i_cost}),
        .i_raddr (cell_raddr),
        .o_rdata (cell_q)
    );

    rcds_ram #(.W(NODE_W), .D(NCELLS), .AW(ADDR_W)) u_dist (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_q)
    );

    // shared multiplier
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;

    rcds_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        case (r_state)
            S_PREP1: begin
                mul_a = MUL_W'(r_csize);
                mul_b = MUL_W'(r_csize);
            end
            S_PREP2: begin
                mul_a = MUL_W'(r_radius) + MUL_W'(1);
                mul_b = MUL_W'(r_radius) + MUL_W'(1);
            end
            S_SC_MUL: begin
                mul_a = MUL_W'(r_g);
                mul_b = MUL_W'(r_cs2);
            end
            S_WGT: begin
                mul_a = MUL_W'(cell_q[COST_W-1:0]);
                mul_b = MUL_W'(DIAG_VAL);
            end
            default: begin
                mul_a = MUL_W'(r_cost);
                mul_b = MUL_W'(DIAG_VAL);
            end
        endcase
    end

    // neighbor address and bounds
    logic signed [1:0] dr, dc;
    logic [ADDR_W:0]   nb_lin;
    logic [ADDR_W-1:0] nb_addr;
    logic              nb_in;

    always_comb begin
        dr     = DIR_ROW[r_dir];
        dc     = DIR_COL[r_dir];
        nb_lin = {1'b0, r_addr};
        nb_in  = 1'b1;
        if (dr == -2'sd1) begin
            nb_lin = nb_lin - (ADDR_W+1)'(w_n);
            nb_in  = nb_in && (r_row != '0);
        end else if (dr == 2'sd1) begin
            nb_lin = nb_lin + (ADDR_W+1)'(w_n);
            nb_in  = nb_in && (r_row != w_nm1);
        end
        if (dc == -2'sd1) begin
            nb_lin = nb_lin - (ADDR_W+1)'(1);
            nb_in  = nb_in && (r_col != '0);
        end else if (dc == 2'sd1) begin
            nb_lin = nb_lin + (ADDR_W+1)'(1);
            nb_in  = nb_in && (r_col != w_nm1);
        end
        nb_addr = nb_lin[ADDR_W-1:0];
    end

    // candidate distance through the neighbor
    logic [DWGT_W-1:0] wgt;
    logic [DIST_W:0]   cand_w;
    logic [DIST_W-1:0] cand;

    always_comb begin
        if (dr != 2'sd0 && dc != 2'sd0) begin
            wgt = mul_p[DWGT_W-1:0];
        end else begin
            wgt = DWGT_W'({r_cost, {FRAC_BITS{1'b0}}});
        end
        cand_w = (DIST_W+1)'(dist_q[DIST_W-1:0]) + (DIST_W+1)'(wgt);
        cand   = cand_w[DIST_W] ? DIST_SAT : cand_w[DIST_W-1:0];
    end

    // scan distance terms
    logic signed [G_W-1:0] sdr, sdc;
    logic [G_W-1:0]        g_next;
    logic [SUM_W:0]        acc_w;

    always_comb begin
        sdr    = $signed(G_W'(r_row)) - $signed(G_W'(r_sr));
        sdc    = $signed(G_W'(r_col)) - $signed(G_W'(r_sc));
        g_next = G_W'(sdr * sdr) + G_W'(sdc * sdc);
        acc_w  = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_val);
    end

    // cell step within a sweep
    logic              at_end;
    logic [POS_W-1:0]  adv_row, adv_col;
    logic [ADDR_W-1:0] adv_addr;

    always_comb begin
        adv_row  = r_row;
        adv_col  = r_col;
        adv_addr = r_addr;
        if (r_fwd) begin
            at_end   = (r_row == w_nm1) && (r_col == w_nm1);
            adv_addr = r_addr + ADDR_W'(1);
            if (r_col == w_nm1) begin
                adv_col = '0;
                adv_row = r_row + POS_W'(1);
            end else begin
                adv_col = r_col + POS_W'(1);
            end
        end else begin
            at_end   = (r_row == '0) && (r_col == '0);
            adv_addr = r_addr - ADDR_W'(1);
            if (r_col == '0) begin
                adv_col = w_nm1;
                adv_row = r_row - POS_W'(1);
            end else begin
                adv_col = r_col - POS_W'(1);
            end
        end
    end

    // memory port control
    always_comb begin
        cell_we    = in_acc && (r_ld_cnt < w_nn);
        cell_raddr = (r_state == S_SEED_RD) ? r_st_addr : r_addr;
        dist_raddr = (r_state == S_NB_RD) ? nb_addr : r_addr;
        dist_we    = 1'b0;
        dist_waddr = r_addr;
        dist_wdata = '0;
        case (r_state)
            S_CLR: begin
                dist_we = 1'b1;
            end
            S_SEED: begin
                dist_we    = r_st_in && !cell_q[COST_W];
                dist_waddr = r_st_addr;
                dist_wdata = {1'b1, DIST_W'({cell_q[COST_W-1:0], {FRAC_BITS{1'b0}}})};
            end
            S_WR: begin
                dist_we    = r_imp;
                dist_wdata = r_best;
            end
            default: begin
                dist_we = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= SIDE_W'(64);
            r_csize   <= 10'd10;
            r_radius  <= 20'd1000;
            r_max_sum <= 31'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SIDE:   r_side    <= i_cfg_data[SIDE_W-1:0];
                CFG_CSIZE:  r_csize   <= i_cfg_data[9:0];
                CFG_RADIUS: r_radius  <= i_cfg_data[19:0];
                CFG_MAXSUM: r_max_sum <= i_cfg_data;
                default:    r_side    <= r_side;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ld_cnt <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // hand the finished result to the output register
            if (r_done && out_free) begin
                r_ovalid <= 1'b1;
                r_osum   <= r_sum;
                r_ocap   <= r_capped;
                r_done   <= 1'b0;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_last) begin
                            r_ld_cnt  <= '0;
                            r_sr      <= i_start_row;
                            r_sc      <= i_start_col;
                            r_st_addr <= ADDR_W'(ADDR_W'(i_start_row) * ADDR_W'(w_n))
                                         + ADDR_W'(i_start_col);
                            r_st_in   <= (SIDE_W'(i_start_row) < w_n)
                                         && (SIDE_W'(i_start_col) < w_n);
                            r_addr    <= '0;
                            r_state   <= S_CLR;
                        end else if (r_ld_cnt < w_nn) begin
                            r_ld_cnt <= r_ld_cnt + CNT_W'(1);
                        end
                    end
                end
                S_CLR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    if (CNT_W'(r_addr) == w_nn - CNT_W'(1)) begin
                        r_state <= S_SEED_RD;
                    end
                end
                S_SEED_RD: begin
                    r_state <= S_SEED;
                end
                S_SEED: begin
                    r_addr    <= '0;
                    r_row     <= '0;
                    r_col     <= '0;
                    r_fwd     <= 1'b1;
                    r_changed <= 1'b0;
                    if (r_st_in && !cell_q[COST_W]) begin
                        r_state <= S_CELL;
                    end else begin
                        r_state <= S_PREP1;
                    end
                end
                S_CELL: begin
                    r_state <= S_WGT;
                end
                S_WGT: begin
                    r_cost <= cell_q[COST_W-1:0];
                    r_best <= dist_q;
                    r_imp  <= 1'b0;
                    r_dir  <= '0;
                    if (cell_q[COST_W]) begin
                        r_state <= S_WR;   // impassable: never written
                    end else begin
                        r_state <= S_NB_RD;
                    end
                end
                S_NB_RD: begin
                    r_nb_ok <= nb_in;
                    r_state <= S_NB_CMP;
                end
                S_NB_CMP: begin
                    if (r_nb_ok && dist_q[DIST_W] &&
                        (!r_best[DIST_W] || cand < r_best[DIST_W-1:0])) begin
                        r_best <= {1'b1, cand};
                        r_imp  <= 1'b1;
                    end
                    r_dir <= r_dir + 3'd1;
                    if (r_dir == 3'd7) begin
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_NB_RD;
                    end
                end
                S_WR: begin
                    r_imp <= 1'b0;
                    if (at_end) begin
                        // sweep done: reverse and repeat while anything moved
                        if (r_changed || r_imp) begin
                            r_fwd     <= !r_fwd;
                            r_changed <= 1'b0;
                            r_state   <= S_CELL;
                        end else begin
                            r_state <= S_PREP1;
                        end
                    end else begin
                        if (r_imp) begin
                            r_changed <= 1'b1;
                        end
                        r_row   <= adv_row;
                        r_col   <= adv_col;
                        r_addr  <= adv_addr;
                        r_state <= S_CELL;
                    end
                end
                S_PREP1: begin
                    r_state <= S_PREP2;
                end
                S_PREP2: begin
                    r_cs2    <= mul_p[19:0];
                    r_addr   <= '0;
                    r_row    <= '0;
                    r_col    <= '0;
                    r_fwd    <= 1'b1;
                    r_sum    <= '0;
                    r_capped <= 1'b0;
                    r_state  <= S_SC_RD;
                end
                S_SC_RD: begin
                    if (r_row == '0 && r_col == '0) begin
                        r_lim <= mul_p;
                    end
                    r_state <= S_SC_G;
                end
                S_SC_G: begin
                    r_hit   <= dist_q[DIST_W];
                    r_val   <= dist_q[DIST_W-1:FRAC_BITS];
                    r_g     <= g_next;
                    r_state <= S_SC_MUL;
                end
                S_SC_MUL: begin
                    r_state <= S_SC_ACC;
                end
                S_SC_ACC: begin
                    if (r_hit && mul_p < r_lim) begin
                        if (r_sum <= SUM_W'(r_max_sum)) begin
                            r_sum <= acc_w[SUM_W] ? {SUM_W{1'b1}} : acc_w[SUM_W-1:0];
                        end else begin
                            r_capped <= 1'b1;
                        end
                    end
                    if (at_end) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_row   <= adv_row;
                        r_col   <= adv_col;
                        r_addr  <= adv_addr;
                        r_state <= S_SC_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_cost_sum  = r_osum;
    assign o_capped    = r_ocap;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_done))
        else $error("result shown without a finished scan");

    a_no_dist_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !dist_we)
        else $error("distance RAM written while idle");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NB_CMP) |-> $past(r_state == S_NB_RD))
        else $error("neighbor compare without a read");

    a_done_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> o_in_stall)
        else $error("word taken while a result is pending");

endmodule
`default_nettype wire

[hdl/rcds_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rcds_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = $clog2(D)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hdl/rcds_mul.sv]
// Shared multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module rcds_mul (
    input  wire logic                        i_clk,
    input  wire logic [rcds_pkg::MUL_W-1:0]  i_a,
    input  wire logic [rcds_pkg::MUL_W-1:0]  i_b,
    output logic      [rcds_pkg::PROD_W-1:0] o_p
);
    import rcds_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

endmodule
`default_nettype wire

[tb/raster_cost_distance_sum_tb.sv]
// Self-checking testbench for the raster cost-distance sum block.
`timescale 1ns / 1ps
`default_nettype none
module raster_cost_distance_sum_tb;
    import rcds_pkg::*;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              outside;
        logic [POS_W-1:0]  srow;
        logic [POS_W-1:0]  scol;
        logic              last;
    } t_cell_word;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             capped;
    } t_sum_word;

    localparam int          WATCHDOG_LIMIT = 2_000_000;
    localparam int          HOLD_CYCLES    = 12000;
    localparam longint      DIAG_Q8        = 362;       // sqrt(2) in Q.8
    localparam logic [30:0] MAXSUM_TOP     = 31'h7FFF_FFFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [COST_W-1:0]     i_cost = '0;
    logic                  i_outside = 1'b0;
    logic [POS_W-1:0]      i_start_row = '0;
    logic [POS_W-1:0]      i_start_col = '0;
    logic                  i_last = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [1:0]            i_cfg_index = '0;
    logic [30:0]           i_cfg_data = '0;
    wire logic             o_in_stall;
    wire logic             o_out_valid;
    wire logic [SUM_W-1:0] o_cost_sum;
    wire logic             o_capped;
    wire logic             o_cfg_ready;

    raster_cost_distance_sum i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cost(i_cost), .i_outside(i_outside),
        .i_start_row(i_start_row), .i_start_col(i_start_col), .i_last(i_last),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cost_sum(o_cost_sum), .o_capped(o_capped),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [SIDE_W-1:0]  win_side = 7'd64;
    logic [9:0]         cell_size = 10'd10;
    logic [19:0]        radius = 20'd1000;
    logic [30:0]        max_sum = 31'd1000;
    logic [CELL_W-1:0]  grid [NCELLS];
    logic [DIST_W-1:0]  path_cost [NCELLS];
    bit                 reached [NCELLS];
    int                 load_idx = 0;
    int                 written_hw = 0;            // entries written since reset

    t_cell_word pending_cells[$];
    t_sum_word  expected_sums[$];
    int         errors = 0;
    int         words_in = 0;
    int         sums_out = 0;
    int         capped_seen = 0;
    int         hold_reqs = 0;
    bit         burst = 1'b0;

    function automatic int side_now();
        if (win_side == 0) return 1;
        if (win_side > MAX_SIDE) return MAX_SIDE;
        return int'(win_side);
    endfunction

    function automatic void predict_sum(t_cell_word w);
        int n, cells, k, u, d, vr, vc, v, sr, sc, r, c, sweep;
        bit changed;
        longint unsigned wgt, s, lim, cs2, d2;
        logic [SUM_W-1:0] acc;
        bit cap;
        t_sum_word res;
        n = side_now();
        cells = n * n;
        if (load_idx < cells) begin
            grid[load_idx] = {w.outside, w.cost};
            load_idx++;
        end
        if (!w.last) return;
        load_idx = 0;
        sr = int'(w.srow);
        sc = int'(w.scol);
        for (k = 0; k < cells; k++) begin
            reached[k] = 1'b0;
            path_cost[k] = '0;
        end
        if (sr < n && sc < n && !grid[sr * n + sc][COST_W]) begin
            k = sr * n + sc;
            path_cost[k] = DIST_W'(grid[k][COST_W-1:0]) << FRAC_BITS;
            reached[k] = 1'b1;
            // relax in alternating sweeps until nothing improves
            sweep = 0;
            do begin
                changed = 1'b0;
                for (k = 0; k < cells; k++) begin
                    u = sweep[0] ? cells - 1 - k : k;
                    if (!reached[u]) continue;
                    for (d = 0; d < 8; d++) begin
                        vr = u / n + int'(DIR_ROW[d]);
                        vc = u % n + int'(DIR_COL[d]);
                        if (vr < 0 || vc < 0 || vr >= n || vc >= n) continue;
                        v = vr * n + vc;
                        if (grid[v][COST_W]) continue;
                        wgt = longint'(grid[v][COST_W-1:0]);
                        wgt = (DIR_ROW[d] != 0 && DIR_COL[d] != 0) ? wgt * DIAG_Q8
                                                                   : wgt << FRAC_BITS;
                        s = longint'(path_cost[u]) + wgt;
                        if (s > longint'(DIST_SAT)) s = longint'(DIST_SAT);
                        if (!reached[v] || s < longint'(path_cost[v])) begin
                            path_cost[v] = DIST_W'(s);
                            reached[v] = 1'b1;
                            changed = 1'b1;
                        end
                    end
                end
                sweep++;
            end while (changed);
        end
        cs2 = longint'(cell_size) * longint'(cell_size);
        lim = (longint'(radius) + 1) * (longint'(radius) + 1);
        acc = '0;
        cap = 1'b0;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                k = r * n + c;
                if (!reached[k]) continue;
                d2 = longint'((r - sr) * (r - sr) + (c - sc) * (c - sc)) * cs2;
                if (d2 >= lim) continue;
                if (acc <= SUM_W'(max_sum)) begin
                    s = longint'(acc) + longint'(path_cost[k] >> FRAC_BITS);
                    acc = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : SUM_W'(s);
                end else begin
                    cap = 1'b1;
                end
            end
        end
        res.sum = acc;
        res.capped = cap;
        expected_sums.push_back(res);
    endfunction

    // driver: present words from the pending queue, hold while stalled
    always @(posedge i_clk) begin
        int gap;
        t_cell_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap = 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                predict_sum({i_cost, i_outside, i_start_row, i_start_col, i_last});
                words_in++;
            end
            if (gap > 0) begin
                gap--;
                i_in_valid <= 1'b0;
            end else if (pending_cells.size() > 0) begin
                w = pending_cells.pop_front();
                i_cost <= w.cost;
                i_outside <= w.outside;
                i_start_row <= w.srow;
                i_start_col <= w.scol;
                i_last <= w.last;
                i_in_valid <= 1'b1;
                if (!burst) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2:    gap = $urandom_range(1, 3);
                        3:          gap = $urandom_range(5, 40);
                        default:    gap = 0;
                    endcase
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        int hold_left, hold_seen;
        t_sum_word e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                sums_out++;
                if (o_capped) capped_seen++;
                if (expected_sums.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: sum %0d capped %0d", o_cost_sum, o_capped);
                end else begin
                    e = expected_sums.pop_front();
                    if (e.sum !== o_cost_sum || e.capped !== o_capped) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected sum %0d capped %0d, got sum %0d capped %0d",
                                     e.sum, e.capped, o_cost_sum, o_capped);
                    end
                end
            end
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst) begin
                i_out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: i_out_stall <= 1'b1;
                    default:    i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        int idle;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle = 0;
        end else begin
            idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", idle);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_cells.size() > 0 || i_in_valid || expected_sums.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [30:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SIDE:   win_side = data[SIDE_W-1:0];
            CFG_CSIZE:  cell_size = data[9:0];
            CFG_RADIUS: radius = data[19:0];
            CFG_MAXSUM: max_sum = data;
            default:    ;
        endcase
    endtask

    task automatic set_regs(int side, int csize, int rad, logic [30:0] msum);
        drain();
        write_reg(CFG_SIDE, 31'(side));
        write_reg(CFG_CSIZE, 31'(csize));
        write_reg(CFG_RADIUS, 31'(rad));
        write_reg(CFG_MAXSUM, msum);
    endtask

    // queue one window; style: 0 any cost, 1 low cost, 2 every cost equal to cval
    task automatic push_window(int cnt, int out_pct, int style, int cval, int sr, int sc);
        t_cell_word w;
        int k, cells;
        cells = side_now() * side_now();
        for (k = 0; k < cnt; k++) begin
            case (style)
                0:       w.cost = COST_W'($urandom);
                1:       w.cost = COST_W'($urandom_range(0, 20));
                default: w.cost = COST_W'(cval);
            endcase
            w.outside = ($urandom_range(0, 99) < out_pct);
            w.srow = POS_W'($urandom);
            w.scol = POS_W'($urandom);
            w.last = (k == cnt - 1);
            if (w.last) begin
                w.srow = POS_W'(sr);
                w.scol = POS_W'(sc);
            end
            pending_cells.push_back(w);
        end
        if (cnt > written_hw) written_hw = (cnt < cells) ? cnt : cells;
    endtask

    task automatic random_window();
        int n, cnt, sr, sc;
        n = side_now();
        cnt = n * n;
        case ($urandom_range(0, 9))
            0:  cnt += $urandom_range(1, 3);
            1:  if (cnt > 1 && written_hw >= cnt) cnt = $urandom_range(1, cnt - 1);
            default: ;
        endcase
        if ($urandom_range(0, 99) < 85) begin
            sr = $urandom_range(0, n - 1);
            sc = $urandom_range(0, n - 1);
        end else begin
            sr = $urandom_range(0, 63);
            sc = $urandom_range(0, 63);
        end
        push_window(cnt, $urandom_range(0, 30), $urandom_range(0, 2), $urandom, sr, sc);
    endtask

    initial begin
        int ph, k, csz;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single cells: zero cost, top cost, blocked start, start off the window
        set_regs(1, 10, 1000, 31'd1000);
        push_window(1, 0, 2, 0, 0, 0);
        push_window(1, 0, 2, 65535, 0, 0);
        push_window(1, 100, 0, 0, 0, 0);
        push_window(1, 0, 0, 0, 5, 63);
        // radius zero, then a sum limit of zero that caps, extra and short windows
        set_regs(2, 1, 0, 31'd0);
        push_window(4, 0, 0, 0, 1, 1);
        set_regs(2, 1000, 1000000, 31'd0);
        push_window(4, 0, 2, 5, 0, 1);
        push_window(7, 0, 0, 0, 1, 0);
        push_window(2, 0, 0, 0, 1, 1);
        set_regs(0, 1, 1000000, MAXSUM_TOP);
        push_window(2, 0, 0, 0, 0, 0);

        // larger full window with equal costs
        set_regs(20, 1, 1000000, MAXSUM_TOP);
        push_window(400, 0, 2, $urandom_range(1, 65535), $urandom_range(0, 19),
                    $urandom_range(0, 19));
        // mostly blocked cells
        set_regs(16, 1000, 20000, 31'd5000);
        push_window(256, 95, 1, 0, 8, 8);

        ph = 0;
        while ((words_in < 1400 || sums_out < 60) && ph < 300) begin
            csz = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 1000 : 1)
                                              : $urandom_range(1, 1000);
            case ($urandom_range(0, 5))
                0:       k = 0;
                1:       k = 1000000;
                default: k = $urandom_range(0, 6 * csz);
            endcase
            set_regs($urandom_range(1, 6), csz, k,
                     ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? MAXSUM_TOP
                                                                              : 31'd0)
                                                 : 31'($urandom_range(0, 3000)));
            burst = ($urandom_range(0, 4) == 0);
            if (ph == 3) hold_reqs <= hold_reqs + 1;   // hold the result side, keep sending
            for (k = 0; k < 6; k++) random_window();
            ph++;
        end

        drain();
        burst = 1'b0;
        errors += expected_sums.size();
        $display("covered %0d cell words, %0d sums (%0d capped) over %0d register settings",
                 words_in, sums_out, capped_seen, ph + 6);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d errors", errors);
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
